// ===== hw/rtl/line_crc32_base41_checksum_macros.svh =====
// ---------------------------------------------------------------------------
// Line CRC-32 checksum assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef LINE_CRC32_BASE41_CHECKSUM_MACROS_SVH
`define LINE_CRC32_BASE41_CHECKSUM_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define LCRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define LCRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lcrcb41_pkg.sv =====
// ---------------------------------------------------------------------------
// Line CRC-32 checksum package
// CRC-32/BZIP2 constants, byte fold and base-41 digit split helpers.
// ---------------------------------------------------------------------------
package lcrcb41_pkg;

    localparam int DIGIT_BASE  = 41;
    localparam int DIGIT_W     = 6;
    localparam int HALF_W      = 16;
    localparam int CRC_W       = 32;
    localparam int BYTE_W      = 8;
    localparam int OUT_TDATA_W = 72;

    // floor(65535 / DIGIT_BASE) fits in 11 bits for the whole base range
    localparam int QB_W = 11;

    // Reciprocals: floor(v * RCP >> SHIFT) == floor(v / D) is exact as long as
    // v * (RCP * D - 2**SHIFT) < 2**SHIFT, which holds for 16-bit v here.
    localparam int RCP_W        = 20;
    localparam int RCP_B_SHIFT  = 24;
    localparam int RCP_SQ_SHIFT = 28;
    localparam int DIGIT_SQ     = DIGIT_BASE * DIGIT_BASE;
    localparam logic [RCP_W-1:0] RCP_B =
        RCP_W'((2 ** RCP_B_SHIFT + DIGIT_BASE - 1) / DIGIT_BASE);
    localparam logic [RCP_W-1:0] RCP_SQ =
        RCP_W'((2 ** RCP_SQ_SHIFT + DIGIT_SQ - 1) / DIGIT_SQ);

    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [DIGIT_W-1:0] d2;
        logic [DIGIT_W-1:0] d1;
        logic [DIGIT_W-1:0] d0;
    } t_digits;

    // Output word, crc in the low bits
    typedef struct packed {
        logic [DIGIT_W-1:0] lo_2;
        logic [DIGIT_W-1:0] lo_1;
        logic [DIGIT_W-1:0] lo_0;
        logic [DIGIT_W-1:0] hi_2;
        logic [DIGIT_W-1:0] hi_1;
        logic [DIGIT_W-1:0] hi_0;
        logic [CRC_W-1:0]   crc;
    } t_result;

    // MSB-first byte fold, eight shift/xor steps
    function automatic logic [CRC_W-1:0] crc_fold(logic [CRC_W-1:0] crc,
                                                 logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, {(CRC_W - BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Three digits, most significant first, from two parallel reciprocal
    // multiplies: q_b = v / B and q_sq = v / B^2.
    function automatic t_digits split_digits(logic [HALF_W-1:0] v);
        logic [HALF_W+RCP_W-1:0] p_b;
        logic [HALF_W+RCP_W-1:0] p_sq;
        logic [QB_W-1:0]         q_b;
        logic [DIGIT_W-1:0]      q_sq;
        logic [QB_W-1:0]         sq_mul;
        logic [HALF_W-1:0]       b_mul;
        t_digits                 d;
        p_b    = {{RCP_W{1'b0}}, v} * {{HALF_W{1'b0}}, RCP_B};
        p_sq   = {{RCP_W{1'b0}}, v} * {{HALF_W{1'b0}}, RCP_SQ};
        q_b    = QB_W'(p_b >> RCP_B_SHIFT);
        q_sq   = DIGIT_W'(p_sq >> RCP_SQ_SHIFT);
        sq_mul = QB_W'(q_sq) * QB_W'(DIGIT_BASE);
        b_mul  = HALF_W'(q_b) * HALF_W'(DIGIT_BASE);
        d.d0   = q_sq;
        d.d1   = DIGIT_W'(q_b - sq_mul);
        d.d2   = DIGIT_W'(v - b_mul);
        return d;
    endfunction

endpackage

// ===== hw/rtl/line_crc32_base41_checksum.sv =====
// ---------------------------------------------------------------------------
// Line CRC-32 checksum with base-41 digit split
// Folds line bytes into a CRC-32/BZIP2 and emits the final CRC plus six
// base-41 digits at the end of each line.
// ---------------------------------------------------------------------------
//
//  channel   dir  fields (tdata / tuser / tlast)
//  s_axis    in   tdata: data_byte | tuser: byte_valid | tlast: end_of_line
//  m_axis    out  tdata: crc_value, six digits (hi_0..hi_2, lo_0..lo_2)
//
//  One input transfer per cycle while s_axis_tready is high. A line result
//  reaches m_axis through two registers: the byte fold runs between the input
//  port and the final-CRC register, the digit split (two reciprocal
//  multiplies per 16-bit half) between that register and the output register.
//  Reset (i_rst_n low, synchronous) reloads the CRC to all ones and drops
//  both pipeline valids. A stall on m_axis backs up through the two stages;
//  s_axis_tready falls only when both hold a result.
//
`include "line_crc32_base41_checksum_macros.svh"

module line_crc32_base41_checksum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lcrcb41_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] data_byte
    input  logic                                s_axis_tuser,  // [0] byte_valid
    input  logic                                s_axis_tlast,  // end_of_line
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] crc_value, [37:32] digit_hi_0, [43:38] digit_hi_1,
    // [49:44] digit_hi_2, [55:50] digit_lo_0, [61:56] digit_lo_1,
    // [67:62] digit_lo_2, [71:68] zero
    output logic [lcrcb41_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lcrcb41_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - $bits(t_result);

    // running CRC and the two pipeline stages
    logic [CRC_W-1:0] r_crc;
    logic [CRC_W-1:0] n_crc;
    logic [CRC_W-1:0] fold_crc;
    logic             r_fin_vld;
    logic [CRC_W-1:0] r_fin;      // final CRC, after output xor
    logic             r_out_vld;
    t_result          r_out;
    t_result          n_out;
    t_digits          dig_hi;
    t_digits          dig_lo;

    logic out_adv;
    logic fin_adv;
    logic in_xfer;
    logic eol_xfer;
    logic digits_ok;

    // stage moves when its successor has room
    assign out_adv       = !r_out_vld || m_axis_tready;
    assign fin_adv       = !r_fin_vld || out_adv;
    assign s_axis_tready = fin_adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign eol_xfer      = in_xfer && s_axis_tlast;

    // byte fold; a transfer with tuser low folds no byte into the CRC
    assign fold_crc = s_axis_tuser ? crc_fold(r_crc, s_axis_tdata) : r_crc;
    assign n_crc    = s_axis_tlast ? CRC_INIT : fold_crc;

    // digit split of the finished CRC
    assign dig_hi     = split_digits(r_fin[CRC_W-1:HALF_W]);
    assign dig_lo     = split_digits(r_fin[HALF_W-1:0]);
    assign n_out.crc  = r_fin;
    assign n_out.hi_0 = dig_hi.d0;
    assign n_out.hi_1 = dig_hi.d1;
    assign n_out.hi_2 = dig_hi.d2;
    assign n_out.lo_0 = dig_lo.d0;
    assign n_out.lo_1 = dig_lo.d1;
    assign n_out.lo_2 = dig_lo.d2;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= CRC_INIT;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_crc <= n_crc;
            end
            if (fin_adv) begin
                r_fin_vld <= in_xfer && s_axis_tlast;
            end
            if (out_adv) begin
                r_out_vld <= r_fin_vld;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tlast) begin
            r_fin <= fold_crc ^ CRC_XOROUT;
        end
        if (out_adv && r_fin_vld) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out};

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------
    assign digits_ok = (r_out.hi_0 < DIGIT_W'(DIGIT_BASE))
                    && (r_out.hi_1 < DIGIT_W'(DIGIT_BASE))
                    && (r_out.hi_2 < DIGIT_W'(DIGIT_BASE))
                    && (r_out.lo_0 < DIGIT_W'(DIGIT_BASE))
                    && (r_out.lo_1 < DIGIT_W'(DIGIT_BASE))
                    && (r_out.lo_2 < DIGIT_W'(DIGIT_BASE));

    `LCRC_ASSERT_NEXT(a_eol_loads_fin, eol_xfer, r_fin_vld, "eol transfer lost")
    `LCRC_ASSERT_NEXT(a_eol_reinit_crc, eol_xfer, r_crc == CRC_INIT, "CRC not reloaded")
    `LCRC_ASSERT_NOW(a_digits_in_range, m_axis_tvalid, digits_ok, "digit out of base range")

endmodule
